FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file ialu_checker.sv
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ialu_pkg.sv
// shared types and constants for the integer alu
// no dependencies
`default_nettype none

package ialu_pkg;

  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int AMT_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_SHL = 3'd3,
    OP_SHR = 3'd4,
    OP_ROL = 3'd5,
    OP_ROR = 3'd6,
    OP_NEG = 3'd7
  } alu_op_t;

  typedef struct packed {
    logic    valid;
    alu_op_t op;
  } stage_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/integer_alu_add_sub_mul_shift_top.sv
// integer alu: add, sub, mul, shifts, rotates, negate on WIDTH-bit words
// an accepted item passes through stages 0, 1 and 2 in order to reach the output
// throughput: one item per cycle while not stalled, three register stages with stall flowing back
// multiply splits into half-word partial products in stage 1, summed in stage 2
// reset clears the stage valid bits only; data registers are not reset
// depends on ialu_pkg, ialu_shift, ialu_mul_pp
`default_nettype none

module integer_alu_add_sub_mul_shift_top
  import ialu_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [DATA_W-1:0] operand_a,
  input  logic [DATA_W-1:0] operand_b,
  input  logic [AMT_W-1:0]  shift_amount,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] result_word
);

  localparam int HALF_W = (WIDTH + 1) / 2;
  localparam int PROD_W = 2 * HALF_W;

  // stage 0: registered operands
  stage_ctrl_t      s0_ctrl;
  logic [WIDTH-1:0] s0_a;
  logic [WIDTH-1:0] s0_b;
  logic [AMT_W-1:0] s0_amt;

  // stage 1: add/shift result and partial products
  stage_ctrl_t       s1_ctrl;
  logic [WIDTH-1:0]  s1_word;
  logic [PROD_W-1:0] s1_lo;
  logic [HALF_W-1:0] s1_hl;
  logic [HALF_W-1:0] s1_lh;

  // stage 2: output register
  logic             s2_valid;
  logic [WIDTH-1:0] s2_word;

  logic adv0, adv1, adv2;

  logic [WIDTH-1:0]  shift_res;
  logic [PROD_W-1:0] pp_lo;
  logic [HALF_W-1:0] pp_hl;
  logic [HALF_W-1:0] pp_lh;
  logic [WIDTH-1:0]  add_x;
  logic [WIDTH-1:0]  add_y;
  logic              add_cin;
  logic [WIDTH-1:0]  add_res;
  logic [WIDTH-1:0]  s1_word_next;
  logic [PROD_W-1:0] prod;
  logic [WIDTH-1:0]  s2_word_next;

  // a stage moves when it is empty or the one after it moves
  assign adv2     = !s2_valid || !out_stall;
  assign adv1     = !s1_ctrl.valid || adv2;
  assign adv0     = !s0_ctrl.valid || adv1;
  assign in_stall = !adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_ctrl.valid <= 1'b0;
    end else if (adv0) begin
      s0_ctrl.valid <= in_valid;
    end
    if (adv0 && in_valid) begin
      s0_ctrl.op <= alu_op_t'(cmd);
      s0_a       <= WIDTH'(operand_a);
      s0_b       <= WIDTH'(operand_b);
      s0_amt     <= shift_amount;
    end
  end

  ialu_shift #(.WIDTH(WIDTH)) u_shift (
    .op  (s0_ctrl.op),
    .a   (s0_a),
    .amt (s0_amt),
    .res (shift_res)
  );

  ialu_mul_pp #(.WIDTH(WIDTH)) u_mul_pp (
    .a     (s0_a),
    .b     (s0_b),
    .pp_lo (pp_lo),
    .pp_hl (pp_hl),
    .pp_lh (pp_lh)
  );

  // one adder for add, sub (a + ~b + 1) and negate (0 + ~a + 1)
  always_comb begin
    add_x   = s0_a;
    add_y   = s0_b;
    add_cin = 1'b0;
    case (s0_ctrl.op)
      OP_SUB: begin
        add_y   = ~s0_b;
        add_cin = 1'b1;
      end
      OP_NEG: begin
        add_x   = '0;
        add_y   = ~s0_a;
        add_cin = 1'b1;
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_res = add_x + add_y + WIDTH'(add_cin);

  always_comb begin
    case (s0_ctrl.op) inside
      OP_ADD, OP_SUB, OP_NEG: s1_word_next = add_res;
      default:                s1_word_next = shift_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl.valid <= 1'b0;
    end else if (adv1) begin
      s1_ctrl.valid <= s0_ctrl.valid;
    end
    if (adv1 && s0_ctrl.valid) begin
      s1_ctrl.op <= s0_ctrl.op;
      s1_word    <= s1_word_next;
      s1_lo      <= pp_lo;
      s1_hl      <= pp_hl;
      s1_lh      <= pp_lh;
    end
  end

  assign prod = s1_lo + {s1_hl, {HALF_W{1'b0}}} + {s1_lh, {HALF_W{1'b0}}};

  assign s2_word_next = (s1_ctrl.op == OP_MUL) ? prod[WIDTH-1:0] : s1_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_ctrl.valid;
    end
    if (adv2 && s1_ctrl.valid) begin
      s2_word <= s2_word_next;
    end
  end

  assign out_valid   = s2_valid;
  assign result_word = DATA_W'(s2_word);

endmodule

`default_nettype wire

FILE: hw/rtl/ialu_shift.sv
// shifter and rotator for the integer alu, combinational
// depends on ialu_pkg
`default_nettype none

module ialu_shift
  import ialu_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  alu_op_t           op,
  input  logic [WIDTH-1:0]  a,
  input  logic [AMT_W-1:0]  amt,
  output logic [WIDTH-1:0]  res
);

  // enough copies of the word that any amount up to the field maximum
  // can be taken as a plain right shift
  localparam int MAX_AMT  = (1 << AMT_W) - 1;
  localparam int REPS     = (MAX_AMT + WIDTH - 1) / WIDTH + 1;
  localparam int REP_W    = REPS * WIDTH;
  localparam int ROT_BASE = (REPS - 1) * WIDTH;
  localparam int SHC_W    = $clog2(REP_W);

  logic [REP_W-1:0] rep;
  logic [SHC_W-1:0] amt_ext;
  logic [SHC_W-1:0] rol_cnt;
  logic [REP_W-1:0] rol_full;
  logic [REP_W-1:0] ror_full;

  assign rep      = {REPS{a}};
  assign amt_ext  = SHC_W'(amt);
  // rotate left by n is a right shift of the copies by a multiple of the width minus n
  assign rol_cnt  = SHC_W'(ROT_BASE) - amt_ext;
  assign rol_full = rep >> rol_cnt;
  assign ror_full = rep >> amt_ext;

  always_comb begin
    case (op)
      OP_SHL:  res = a << amt;
      OP_SHR:  res = a >> amt;
      OP_ROL:  res = rol_full[WIDTH-1:0];
      OP_ROR:  res = ror_full[WIDTH-1:0];
      default: res = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ialu_mul_pp.sv
// partial products for the low half of a word multiply
// depends on ialu_pkg; each multiplier is at most half a word square
`default_nettype none

module ialu_mul_pp
  import ialu_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0]    a,
  input  logic [WIDTH-1:0]    b,
  output logic [2*((WIDTH+1)/2)-1:0] pp_lo,
  output logic [(WIDTH+1)/2-1:0]     pp_hl,
  output logic [(WIDTH+1)/2-1:0]     pp_lh
);

  localparam int HALF_W = (WIDTH + 1) / 2;
  localparam int PROD_W = 2 * HALF_W;

  logic [PROD_W-1:0] a_ext;
  logic [PROD_W-1:0] b_ext;
  logic [PROD_W-1:0] hl_full;
  logic [PROD_W-1:0] lh_full;

  assign a_ext = PROD_W'(a);
  assign b_ext = PROD_W'(b);

  assign pp_lo   = a_ext[HALF_W-1:0] * b_ext[HALF_W-1:0];
  // cross terms land one half up, so only their low half survives
  assign hl_full = a_ext[PROD_W-1:HALF_W] * b_ext[HALF_W-1:0];
  assign lh_full = a_ext[HALF_W-1:0] * b_ext[PROD_W-1:HALF_W];
  assign pp_hl   = hl_full[HALF_W-1:0];
  assign pp_lh   = lh_full[HALF_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/ialu_checker.sv
// port-level checks for the integer alu, bound to the top level
// depends on ialu_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ialu_checker
  import ialu_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [DATA_W-1:0] result_word
);

  // nothing comes out the cycle after reset
  `ASSERT_CLK_NR(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

  // a stalled result stays put
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(result_word), "stalled result changed")

  // input only backs up when every stage is full and the output is stalled
  `ASSERT_CLK(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall, "input stalled with room in the pipeline")

  // with the output flowing an item that enters moves through stages 0, 1 and 2 to the output
  `ASSERT_CLK(a_latency, clk, rst, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid, "item did not reach the output in time")

endmodule

bind integer_alu_add_sub_mul_shift_top ialu_checker u_ialu_checker (.*);

`default_nettype wire

FILE: tb/integer_alu_add_sub_mul_shift_tb.sv
// self-checking bench for the integer alu top: directed corner items, then random bursts
// a small scoreboard predicts each result word from the accepted item and checks it in order
// depends on ialu_pkg and integer_alu_add_sub_mul_shift_top
module tb
  import ialu_pkg::*;
;

  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_LIMIT = 10;

  // receiver stall patterns
  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_PERIOD = 3;

  class alu_result_checker;
    typedef struct {
      alu_op_t           op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [AMT_W-1:0]  amt;
      logic [DATA_W-1:0] word;
    } alu_expect_t;

    alu_expect_t expected_words[$];
    int fail_count = 0;

    function automatic logic [DATA_W-1:0] predict_word(alu_op_t op, logic [DATA_W-1:0] a,
                                                       logic [DATA_W-1:0] b,
                                                       logic [AMT_W-1:0] amt);
      logic [AMT_W-1:0] rot;
      rot = AMT_W'(amt % DATA_W);
      case (op)
        OP_ADD: return a + b;
        OP_SUB: return a + (~b + 1'b1);
        OP_MUL: return a * b;
        OP_SHL: return (amt >= DATA_W) ? '0 : a << amt;
        OP_SHR: return (amt >= DATA_W) ? '0 : a >> amt;
        OP_ROL: return (rot == 0) ? a : (a << rot) | (a >> (DATA_W - rot));
        OP_ROR: return (rot == 0) ? a : (a >> rot) | (a << (DATA_W - rot));
        default: return ~a + 1'b1;
      endcase
    endfunction

    function void note_item(alu_op_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                            logic [AMT_W-1:0] amt);
      alu_expect_t e;
      e.op = op;
      e.a = a;
      e.b = b;
      e.amt = amt;
      e.word = predict_word(op, a, b, amt);
      expected_words.push_back(e);
    endfunction

    function void check_result(logic [DATA_W-1:0] got);
      alu_expect_t e;
      if (expected_words.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $display("unexpected result word %h with no item outstanding", got);
        fail_count++;
        return;
      end
      e = expected_words.pop_front();
      if (got !== e.word) begin
        if (fail_count < REPORT_LIMIT)
          $display("mismatch %s a=%h b=%h amt=%0d: expected %h, got %h",
                   e.op.name(), e.a, e.b, e.amt, e.word, got);
        fail_count++;
      end
    endfunction

    function int waiting();
      return expected_words.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;
  logic [AMT_W-1:0]  shift_amount;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] result_word;

  alu_result_checker results_chk;
  int stall_mode = STALL_NONE;
  int stall_left = 0;

  integer_alu_add_sub_mul_shift_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .shift_amount (shift_amount),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_word  (result_word)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: pick a stall pattern, hold it for a while, then pick again
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_PERIOD);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      results_chk.check_result(result_word);
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(alu_op_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                           logic [AMT_W-1:0] amt);
    @(negedge clk);
    in_valid     <= 1'b1;
    cmd          <= op;
    operand_a    <= a;
    operand_b    <= b;
    shift_amount <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_chk.note_item(op, a, b, amt);
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // stop sending and wait for every outstanding item to come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_chk.waiting() != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    results_chk = new();
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = OP_ADD;
    operand_a = '0;
    operand_b = '0;
    shift_amount = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners: wrap-around, extreme amounts, unused operands carrying junk
    send_item(OP_ADD, '0, '0, 6'd32);
    send_item(OP_ADD, '1, 32'h1, 6'd0);
    send_item(OP_ADD, 32'h7fff_ffff, 32'h1, 6'd17);
    send_item(OP_SUB, '0, 32'h1, 6'd0);
    send_item(OP_SUB, 32'h5, 32'h5, 6'd32);
    send_item(OP_SUB, '0, 32'h8000_0000, 6'd1);
    send_item(OP_MUL, '1, '1, 6'd0);
    send_item(OP_MUL, 32'h0001_0000, 32'h0001_0000, 6'd31);
    send_item(OP_MUL, 32'd12345, 32'd6789, 6'd5);
    send_item(OP_SHL, '1, 32'hdead_beef, 6'd0);
    send_item(OP_SHL, 32'h8000_0001, '1, 6'd1);
    send_item(OP_SHL, '1, '0, 6'd31);
    send_item(OP_SHL, '1, '1, 6'd32);
    send_item(OP_SHR, '1, 32'h1234_5678, 6'd0);
    send_item(OP_SHR, '1, '0, 6'd31);
    send_item(OP_SHR, '1, '1, 6'd32);
    send_item(OP_ROL, 32'h8000_0001, '1, 6'd0);
    send_item(OP_ROL, 32'h8000_0001, '0, 6'd1);
    send_item(OP_ROL, 32'h1234_5678, '1, 6'd32);
    send_item(OP_ROL, 32'h8000_0001, '0, 6'd31);
    send_item(OP_ROR, 32'h8000_0001, '1, 6'd1);
    send_item(OP_ROR, 32'h1234_5678, '0, 6'd32);
    send_item(OP_NEG, '0, '1, 6'd7);
    send_item(OP_NEG, 32'h8000_0000, '0, 6'd32);
    send_item(OP_NEG, 32'h1, '1, 6'd0);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_item(alu_op_t'($urandom_range(0, 7)), pick_word(), pick_word(),
                  AMT_W'($urandom_range(0, DATA_W)));
        sent++;
        if (sent == RANDOM_ITEMS / 2)
          drain_results();
      end
      hold_off(gap);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (results_chk.fail_count == 0 && results_chk.waiting() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: integer_alu_add_sub_mul_shift_top.f
+incdir+hw/rtl
hw/rtl/ialu_pkg.sv
hw/rtl/ialu_shift.sv
hw/rtl/ialu_mul_pp.sv
hw/rtl/integer_alu_add_sub_mul_shift_top.sv
hw/rtl/ialu_checker.sv
tb/integer_alu_add_sub_mul_shift_tb.sv
